// ----- hw/rtl/sdf_pkg.sv -----
// Shared constants, types and a saturation helper of the spring damper force block.
package sdf_pkg;

    // Fraction bits of every Q value
    localparam int FRAC_BITS = 16;

    // Unit direction components lie in [-1.0, 1.0]
    localparam int DIR_W = FRAC_BITS + 2;

    // Shared multiplier: signed operands and full product
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Shared square root and divide unit
    localparam int ITER_REM_W = 37;
    localparam int ITER_SH_W  = 66;
    localparam int ROOT_W     = 33;
    localparam int CNT_W      = 6;

    // Width used ahead of saturation to 32 bits
    localparam int SAT_W = 68;

    // Configuration register indexes
    localparam logic [1:0] CFG_REST_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_STIFFNESS    = 2'd1;
    localparam logic [1:0] CFG_DAMPING      = 2'd2;
    localparam logic [1:0] CFG_ENABLED      = 2'd3;

    // Command to the square root and divide unit
    typedef struct packed {
        logic             start;
        logic             is_sqrt;
        logic [CNT_W-1:0] steps;
    } iter_cmd_t;

    // Saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi_lim;
        logic signed [SAT_W-1:0] lo_lim;
        hi_lim = SAT_W'(33'sh0_7FFF_FFFF);
        lo_lim = SAT_W'(33'sh1_8000_0000);
        if (v > hi_lim) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo_lim) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- hw/rtl/sdf_mul.sv -----
// Shared signed multiplier with a registered product.
module sdf_mul
    import sdf_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // One multiply per cycle, result visible the next cycle
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/sdf_iter.sv -----
// Shared restoring square root and divide unit, one result bit per cycle.
module sdf_iter
    import sdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  iter_cmd_t             cmd,
    input  logic [ITER_REM_W-1:0] rem_init,
    input  logic [ITER_SH_W-1:0]  sh_init,
    input  logic [ROOT_W-1:0]     den,
    output logic                  done,
    output logic [ROOT_W-1:0]     result
);

    logic [ITER_REM_W-1:0] rem_reg, rem_next;
    logic [ITER_SH_W-1:0]  sh_reg, sh_next;
    logic [ROOT_W-1:0]     acc_reg, acc_next;
    logic [ROOT_W-1:0]     den_reg;
    logic                  sqrt_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [ITER_REM_W-1:0] shifted;
    logic [ITER_REM_W-1:0] trial;

    // One step: bring in the next bits, compare against the trial value
    always_comb begin
        if (sqrt_reg) begin
            shifted = {rem_reg[ITER_REM_W-3:0], sh_reg[ITER_SH_W-1 -: 2]};
            trial   = ITER_REM_W'({acc_reg, 2'b01});
            sh_next = {sh_reg[ITER_SH_W-3:0], 2'b00};
        end else begin
            shifted = {rem_reg[ITER_REM_W-2:0], sh_reg[ITER_SH_W-1]};
            trial   = ITER_REM_W'(den_reg);
            sh_next = {sh_reg[ITER_SH_W-2:0], 1'b0};
        end
        if (shifted >= trial) begin
            rem_next = shifted - trial;
            acc_next = {acc_reg[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next = shifted;
            acc_next = {acc_reg[ROOT_W-2:0], 1'b0};
        end
        cnt_next  = cnt_reg - CNT_W'(1);
        done_next = (cnt_reg == CNT_W'(1));
    end

    // Control: step count and completion pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (cmd.start) begin
            cnt_reg  <= cmd.steps;
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rem_reg  <= rem_init;
            sh_reg   <= sh_init;
            acc_reg  <= '0;
            den_reg  <= den;
            sqrt_reg <= cmd.is_sqrt;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
            acc_reg <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ----- hw/rtl/spring_damper_force_core.sv -----
// Top level of the damped spring force block: sequencer, configuration and output word.
//
// Usage: the input channel (s_valid / s_ready) carries one word with the positions,
// velocities, masses and kinematic flags of two bodies. The result channel
// (m_valid / m_ready) returns one word per input word with the four force
// components and the applied flag. The configuration channel (cfg_valid /
// cfg_ready, cfg_index, cfg_data) writes rest length, stiffness, damping and
// enable; cfg_ready is always high and writes are meant for idle periods.
// A disabled or fully kinematic word goes straight from idle to the done state.
// A full word runs its passes through the shared square root and divide unit,
// one result bit per cycle: the length, each direction component, and for
// critical damping a reduced mass division, a square root and two multiplies; a zero
// distance skips the direction divisions.
// One word is in work at a time; s_ready is high only while the sequencer idles,
// and it rises at the same edge as m_valid, when the word leaves the done state.
// A stalled receiver does not hold off the next word: it is taken and computed,
// then waits in the sequencer until the output register is free again.
// Reset restores the configuration defaults and clears the held direction.
module spring_damper_force_core
    import sdf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_a_x,
    input  logic signed [31:0] s_pos_a_y,
    input  logic signed [31:0] s_pos_b_x,
    input  logic signed [31:0] s_pos_b_y,
    input  logic signed [31:0] s_vel_a_x,
    input  logic signed [31:0] s_vel_a_y,
    input  logic signed [31:0] s_vel_b_x,
    input  logic signed [31:0] s_vel_b_y,
    input  logic [30:0]        s_mass_a,
    input  logic [30:0]        s_mass_b,
    input  logic               s_fixed_a,
    input  logic               s_fixed_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_force_a_x,
    output logic signed [31:0] m_force_a_y,
    output logic signed [31:0] m_force_b_x,
    output logic signed [31:0] m_force_b_y,
    output logic               m_applied,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    typedef enum logic [24:0] {
        ST_IDLE    = 25'b1 << 0,
        ST_SQX     = 25'b1 << 1,
        ST_SQY     = 25'b1 << 2,
        ST_LEN_GO  = 25'b1 << 3,
        ST_LEN     = 25'b1 << 4,
        ST_DIRX_GO = 25'b1 << 5,
        ST_DIRX    = 25'b1 << 6,
        ST_DIRY_GO = 25'b1 << 7,
        ST_DIRY    = 25'b1 << 8,
        ST_FS      = 25'b1 << 9,
        ST_DOT1    = 25'b1 << 10,
        ST_DOT2    = 25'b1 << 11,
        ST_DOT3    = 25'b1 << 12,
        ST_MM      = 25'b1 << 13,
        ST_RM_GO   = 25'b1 << 14,
        ST_RM      = 25'b1 << 15,
        ST_KM      = 25'b1 << 16,
        ST_CS_GO   = 25'b1 << 17,
        ST_CS      = 25'b1 << 18,
        ST_FD      = 25'b1 << 19,
        ST_FSUM    = 25'b1 << 20,
        ST_GX      = 25'b1 << 21,
        ST_GY      = 25'b1 << 22,
        ST_GYS     = 25'b1 << 23,
        ST_DONE    = 25'b1 << 24
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [30:0]        rest_length_reg;
    logic [30:0]        stiffness_reg;
    logic signed [31:0] damping_reg;
    logic               enabled_reg;

    // Held unit direction
    logic signed [DIR_W-1:0] dirx_reg, diry_reg;

    // Item registers
    logic signed [32:0] dx_reg, dy_reg, vrx_reg, vry_reg;
    logic [30:0]        ma_reg, mb_reg;
    logic               fa_reg, fb_reg;

    // Working registers
    logic signed [PROD_W-1:0] wide_reg;
    logic [ROOT_W-1:0]        len_reg;
    logic signed [31:0]       fs_reg, dot_reg, c_reg, f_reg, gx_reg, gy_reg;
    logic [30:0]              m_reg;
    logic                     applied_reg;

    // Output word
    logic               m_valid_reg;
    logic signed [31:0] fax_reg, fay_reg, fbx_reg, fby_reg;
    logic               m_applied_reg;

    // Shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    iter_cmd_t                iter_cmd;
    logic [ITER_REM_W-1:0]    iter_rem;
    logic [ITER_SH_W-1:0]     iter_sh;
    logic [ROOT_W-1:0]        iter_den;
    logic                     iter_done;
    logic [ROOT_W-1:0]        iter_res;

    // Derived values
    logic [31:0]               ax, ay;
    logic signed [31:0]        x_val;
    logic [31:0]               mass_sum;
    logic [4:0]                out_shift;
    logic signed [DIR_W-1:0]   q_dir;
    logic signed [31:0]        fd_val;
    logic                      out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign ax        = dx_reg[32] ? 32'(-dx_reg) : dx_reg[31:0];
    assign ay        = dy_reg[32] ? 32'(-dy_reg) : dy_reg[31:0];
    assign x_val     = sat32($signed({35'b0, len_reg}) - $signed({37'b0, rest_length_reg}));
    assign mass_sum  = {1'b0, ma_reg} + {1'b0, mb_reg};
    assign out_shift = (fa_reg || fb_reg) ? 5'(FRAC_BITS) : 5'(FRAC_BITS + 1);
    assign q_dir     = $signed({1'b0, iter_res[FRAC_BITS:0]});
    assign fd_val    = sat32(SAT_W'((-mul_p) >>> FRAC_BITS));
    assign out_free  = !m_valid_reg || m_ready;

    sdf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    sdf_iter u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (iter_cmd),
        .rem_init (iter_rem),
        .sh_init  (iter_sh),
        .den      (iter_den),
        .done     (iter_done),
        .result   (iter_res)
    );

    // Multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin
                mul_a = $signed({1'b0, ax});
                mul_b = $signed({1'b0, ax});
            end
            ST_SQY: begin
                mul_a = $signed({1'b0, ay});
                mul_b = $signed({1'b0, ay});
            end
            ST_FS: begin
                mul_a = $signed({2'b0, stiffness_reg});
                mul_b = MUL_W'(x_val);
            end
            ST_DOT1: begin
                mul_a = vrx_reg;
                mul_b = MUL_W'(dirx_reg);
            end
            ST_DOT2: begin
                mul_a = vry_reg;
                mul_b = MUL_W'(diry_reg);
            end
            ST_MM: begin
                mul_a = $signed({2'b0, ma_reg});
                mul_b = $signed({2'b0, mb_reg});
            end
            ST_KM: begin
                mul_a = $signed({2'b0, stiffness_reg});
                mul_b = $signed({2'b0, m_reg});
            end
            ST_FD: begin
                mul_a = MUL_W'(c_reg);
                mul_b = MUL_W'(dot_reg);
            end
            ST_GX: begin
                mul_a = MUL_W'(f_reg);
                mul_b = MUL_W'(dirx_reg);
            end
            ST_GY: begin
                mul_a = MUL_W'(f_reg);
                mul_b = MUL_W'(diry_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Square root and divide commands
    always_comb begin
        iter_cmd = '0;
        iter_rem = '0;
        iter_sh  = '0;
        iter_den = len_reg;
        case (state_reg)
            ST_LEN_GO: begin
                iter_cmd.start   = 1'b1;
                iter_cmd.is_sqrt = 1'b1;
                iter_cmd.steps   = CNT_W'(ROOT_W);
                iter_sh          = ITER_SH_W'($unsigned(wide_reg) + $unsigned(mul_p));
            end
            ST_DIRX_GO: begin
                iter_cmd.start = 1'b1;
                iter_cmd.steps = CNT_W'(FRAC_BITS + 1);
                iter_rem       = ITER_REM_W'(ax >> 1);
                iter_sh        = {ax[0], {(ITER_SH_W-1){1'b0}}};
            end
            ST_DIRY_GO: begin
                iter_cmd.start = 1'b1;
                iter_cmd.steps = CNT_W'(FRAC_BITS + 1);
                iter_rem       = ITER_REM_W'(ay >> 1);
                iter_sh        = {ay[0], {(ITER_SH_W-1){1'b0}}};
            end
            ST_RM_GO: begin
                iter_cmd.start = (mass_sum != '0);
                iter_cmd.steps = CNT_W'(31);
                iter_rem       = ITER_REM_W'(mul_p[61:31]);
                iter_sh        = {mul_p[30:0], 35'b0};
                iter_den       = ROOT_W'(mass_sum);
            end
            ST_CS_GO: begin
                iter_cmd.start   = 1'b1;
                iter_cmd.is_sqrt = 1'b1;
                iter_cmd.steps   = CNT_W'(ROOT_W);
                iter_sh          = ITER_SH_W'($unsigned(mul_p));
            end
            default: begin
                iter_cmd = '0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!enabled_reg || (s_fixed_a && s_fixed_b)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SQX;
                    end
                end
            end
            ST_SQX:     state_next = ST_SQY;
            ST_SQY:     state_next = ST_LEN_GO;
            ST_LEN_GO:  state_next = ST_LEN;
            ST_LEN: begin
                if (iter_done) begin
                    state_next = (iter_res != '0) ? ST_DIRX_GO : ST_FS;
                end
            end
            ST_DIRX_GO: state_next = ST_DIRX;
            ST_DIRX: begin
                if (iter_done) begin
                    state_next = ST_DIRY_GO;
                end
            end
            ST_DIRY_GO: state_next = ST_DIRY;
            ST_DIRY: begin
                if (iter_done) begin
                    state_next = ST_FS;
                end
            end
            ST_FS:      state_next = ST_DOT1;
            ST_DOT1:    state_next = ST_DOT2;
            ST_DOT2:    state_next = ST_DOT3;
            ST_DOT3:    state_next = damping_reg[31] ? ST_MM : ST_FD;
            ST_MM:      state_next = ST_RM_GO;
            ST_RM_GO:   state_next = (mass_sum != '0) ? ST_RM : ST_KM;
            ST_RM: begin
                if (iter_done) begin
                    state_next = ST_KM;
                end
            end
            ST_KM:      state_next = ST_CS_GO;
            ST_CS_GO:   state_next = ST_CS;
            ST_CS: begin
                if (iter_done) begin
                    state_next = ST_FD;
                end
            end
            ST_FD:      state_next = ST_FSUM;
            ST_FSUM:    state_next = ST_GX;
            ST_GX:      state_next = ST_GY;
            ST_GY:      state_next = ST_GYS;
            ST_GYS:     state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and held direction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            rest_length_reg <= 31'(1 << FRAC_BITS);
            stiffness_reg   <= '0;
            damping_reg     <= '0;
            enabled_reg     <= 1'b1;
            dirx_reg        <= '0;
            diry_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_REST_LENGTH: rest_length_reg <= cfg_data[30:0];
                    CFG_STIFFNESS:   stiffness_reg   <= cfg_data[30:0];
                    CFG_DAMPING:     damping_reg     <= $signed(cfg_data);
                    CFG_ENABLED:     enabled_reg     <= cfg_data[0];
                    default:         enabled_reg     <= enabled_reg;
                endcase
            end
            if (state_reg == ST_DIRX && iter_done) begin
                dirx_reg <= dx_reg[32] ? -q_dir : q_dir;
            end
            if (state_reg == ST_DIRY && iter_done) begin
                diry_reg <= dy_reg[32] ? -q_dir : q_dir;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture and working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                dx_reg      <= 33'(s_pos_b_x) - 33'(s_pos_a_x);
                dy_reg      <= 33'(s_pos_b_y) - 33'(s_pos_a_y);
                vrx_reg     <= 33'(s_vel_b_x) - 33'(s_vel_a_x);
                vry_reg     <= 33'(s_vel_b_y) - 33'(s_vel_a_y);
                ma_reg      <= s_mass_a;
                mb_reg      <= s_mass_b;
                fa_reg      <= s_fixed_a;
                fb_reg      <= s_fixed_b;
                gx_reg      <= '0;
                gy_reg      <= '0;
                applied_reg <= enabled_reg && !(s_fixed_a && s_fixed_b);
            end
            ST_SQY:  wide_reg <= mul_p;
            ST_LEN: begin
                if (iter_done) begin
                    len_reg <= iter_res;
                end
            end
            ST_DOT1: begin
                fs_reg   <= sat32(SAT_W'((-mul_p) >>> FRAC_BITS));
                wide_reg <= '0;
            end
            ST_DOT2: wide_reg <= mul_p;
            ST_DOT3: begin
                dot_reg <= sat32(SAT_W'((wide_reg + mul_p) >>> FRAC_BITS));
                c_reg   <= damping_reg;
            end
            ST_RM_GO: m_reg <= '0;
            ST_RM: begin
                if (iter_done) begin
                    m_reg <= iter_res[30:0];
                end
            end
            ST_CS: begin
                if (iter_done) begin
                    c_reg <= sat32(SAT_W'({iter_res, 1'b0}));
                end
            end
            ST_FSUM: f_reg <= sat32(SAT_W'(fs_reg) + SAT_W'(fd_val));
            ST_GY:   gx_reg <= sat32(SAT_W'(mul_p >>> out_shift));
            ST_GYS:  gy_reg <= sat32(SAT_W'(mul_p >>> out_shift));
            default: begin
                applied_reg <= applied_reg;
            end
        endcase
    end

    // Output word: forces on free bodies only, body A gets the opposite sign
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            fbx_reg       <= fb_reg ? 32'sd0 : gx_reg;
            fby_reg       <= fb_reg ? 32'sd0 : gy_reg;
            fax_reg       <= fa_reg ? 32'sd0 : sat32(-SAT_W'(gx_reg));
            fay_reg       <= fa_reg ? 32'sd0 : sat32(-SAT_W'(gy_reg));
            m_applied_reg <= applied_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_force_a_x = fax_reg;
    assign m_force_a_y = fay_reg;
    assign m_force_b_x = fbx_reg;
    assign m_force_b_y = fby_reg;
    assign m_applied   = m_applied_reg;

endmodule

// ----- hw/rtl/sdf_checker.sv -----
// Port-level checks of the damped spring force block and their binding.
module sdf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_force_a_x,
    input logic signed [31:0] m_force_a_y,
    input logic signed [31:0] m_force_b_x,
    input logic signed [31:0] m_force_b_y,
    input logic               m_applied
);

    // A stalled result word stays valid and holds force A x, force B y and the applied flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_force_a_x) && $stable(m_force_b_y)
            && $stable(m_applied))
        else $error("stalled result word changed");

    // A skipped word carries zero forces
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_applied |-> m_force_a_x == 0 && m_force_a_y == 0
            && m_force_b_x == 0 && m_force_b_y == 0)
        else $error("skipped word has nonzero force");

    // Only one word is in work: the input closes right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in work");

    // No result can appear in the cycle right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind spring_damper_force_core sdf_checker u_sdf_checker (.*);

// ----- tb/sdf_force_checker.sv -----
// Checker for the spring damper force core: predicts each result word and compares it.
`timescale 1ns / 100ps

module sdf_force_checker
    import sdf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_pos_a_x,
    input  logic signed [31:0] s_pos_a_y,
    input  logic signed [31:0] s_pos_b_x,
    input  logic signed [31:0] s_pos_b_y,
    input  logic signed [31:0] s_vel_a_x,
    input  logic signed [31:0] s_vel_a_y,
    input  logic signed [31:0] s_vel_b_x,
    input  logic signed [31:0] s_vel_b_y,
    input  logic [30:0]        s_mass_a,
    input  logic [30:0]        s_mass_b,
    input  logic               s_fixed_a,
    input  logic               s_fixed_b,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_force_a_x,
    input  logic signed [31:0] m_force_a_y,
    input  logic signed [31:0] m_force_b_x,
    input  logic signed [31:0] m_force_b_y,
    input  logic               m_applied,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 forces_pending,
    output int                 forces_checked
);

    typedef struct packed {
        logic signed [31:0] fax;
        logic signed [31:0] fay;
        logic signed [31:0] fbx;
        logic signed [31:0] fby;
        logic               applied;
    } force_word_t;

    // Mirrored configuration and held unit direction
    logic [30:0]        rest_len;
    logic [30:0]        spring_k;
    logic signed [31:0] damp_c;
    logic               enable;
    longint             held_nx;
    longint             held_ny;

    force_word_t expected_forces[$];

    // Floor square root of a 66-bit value, two bits per step.
    function automatic longint floor_sqrt(input logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [33:0] root;
        rem  = '0;
        root = '0;
        for (int b = 65; b >= 1; b -= 2) begin
            rem   = (rem << 2) | 68'(v[b -: 2]);
            trial = (68'(root) << 2) | 68'd1;
            root  = root << 1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = root | 34'd1;
            end
        end
        return longint'(root);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unit_part(input longint d, input longint len);
        longint q;
        q = ((d < 0 ? -d : d) <<< FRAC_BITS) / len;
        return d < 0 ? -q : q;
    endfunction

    // Force prediction for one accepted input word; updates the held direction.
    function automatic force_word_t predict_forces();
        force_word_t r;
        longint dx, dy, ax, ay, len, stretch, f_spring, vrx, vry, dot, c, f_damp, f, gx, gy;
        longint unsigned ma, mb, den, mred;
        logic [65:0] sq;
        int sh;
        r = '0;
        if (!enable || (s_fixed_a && s_fixed_b)) return r;
        dx = longint'(s_pos_b_x) - longint'(s_pos_a_x);
        dy = longint'(s_pos_b_y) - longint'(s_pos_a_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        len = floor_sqrt(sq);
        if (len != 0) begin
            held_nx = unit_part(dx, len);
            held_ny = unit_part(dy, len);
        end
        stretch  = clamp32(len - longint'(rest_len));
        f_spring = clamp32(-(longint'(spring_k) * stretch) >>> FRAC_BITS);
        vrx = longint'(s_vel_b_x) - longint'(s_vel_a_x);
        vry = longint'(s_vel_b_y) - longint'(s_vel_a_y);
        dot = clamp32((vrx * held_nx + vry * held_ny) >>> FRAC_BITS);
        c = longint'(damp_c);
        // Negative damping selects critical damping from the reduced mass.
        if (c < 0) begin
            ma   = s_mass_a;
            mb   = s_mass_b;
            den  = ma + mb;
            mred = den != 0 ? (ma * mb) / den : 0;
            c    = clamp32(2 * floor_sqrt(66'(longint'(spring_k) * longint'(mred))));
        end
        f_damp = clamp32(-(c * dot) >>> FRAC_BITS);
        f      = clamp32(f_spring + f_damp);
        sh = (s_fixed_a || s_fixed_b) ? FRAC_BITS : FRAC_BITS + 1;
        gx = clamp32((f * held_nx) >>> sh);
        gy = clamp32((f * held_ny) >>> sh);
        if (!s_fixed_b) begin
            r.fbx = gx[31:0];
            r.fby = gy[31:0];
        end
        if (!s_fixed_a) begin
            r.fax = 32'(clamp32(-gx));
            r.fay = 32'(clamp32(-gy));
        end
        r.applied = 1'b1;
        return r;
    endfunction

    assign forces_pending = expected_forces.size();

    // Watch all three channels at each rising edge.
    always @(posedge aclk) begin
        force_word_t want;
        force_word_t got;
        if (!aresetn) begin
            rest_len = 31'(1 << FRAC_BITS);
            spring_k = '0;
            damp_c   = '0;
            enable   = 1'b1;
            held_nx  = 0;
            held_ny  = 0;
            expected_forces.delete();
            fail_count     = 0;
            forces_checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REST_LENGTH: rest_len = cfg_data[30:0];
                    CFG_STIFFNESS:   spring_k = cfg_data[30:0];
                    CFG_DAMPING:     damp_c   = cfg_data;
                    CFG_ENABLED:     enable   = cfg_data[0];
                    default:         enable   = enable;
                endcase
            end
            // Retire the result word before queueing a new expectation.
            if (m_valid && m_ready) begin
                got = '{m_force_a_x, m_force_a_y, m_force_b_x, m_force_b_y, m_applied};
                if (expected_forces.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word %p", got);
                end else begin
                    want = expected_forces.pop_front();
                    forces_checked++;
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d: expected %p, got %p",
                                     forces_checked, want, got);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_forces.push_back(predict_forces());
        end
    end

endmodule

// ----- tb/tb_spring_damper_force_core.sv -----
// Testbench top for the spring damper force core: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_spring_damper_force_core;
    import sdf_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 150;

    typedef struct {
        logic signed [31:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
        logic [30:0]        ma, mb;
        logic               fa, fb;
    } bodies_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_pos_a_x = '0, s_pos_a_y = '0, s_pos_b_x = '0, s_pos_b_y = '0;
    logic signed [31:0] s_vel_a_x = '0, s_vel_a_y = '0, s_vel_b_x = '0, s_vel_b_y = '0;
    logic [30:0]        s_mass_a = 31'd1, s_mass_b = 31'd1;
    logic               s_fixed_a = 1'b0, s_fixed_b = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_force_a_x, m_force_a_y, m_force_b_x, m_force_b_y;
    logic               m_applied;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    int  fail_count, forces_pending, forces_checked;
    int  words_sent = 0;
    int  settings_run = 0;
    int  idle_cycles = 0;
    int  rx_stall = 0;
    bit  idling_on = 1'b1;

    always #5 aclk = ~aclk;

    spring_damper_force_core i_dut (.*);

    sdf_force_checker i_checker (.*);

    // Receiver side: random stalls, most short and a few long.
    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
            if (idling_on && $urandom_range(0, 99) < 30)
                rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 3);
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("spring_damper_force_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int sender_gap();
        int r;
        if (!idling_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Push one input word; valid stays high if the next word follows at once.
    task automatic send_bodies(input bodies_t w);
        int g;
        g = sender_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_pos_a_x <= w.pax; s_pos_a_y <= w.pay; s_pos_b_x <= w.pbx; s_pos_b_y <= w.pby;
        s_vel_a_x <= w.vax; s_vel_a_y <= w.vay; s_vel_b_x <= w.vbx; s_vel_b_y <= w.vby;
        s_mass_a <= w.ma; s_mass_b <= w.mb; s_fixed_a <= w.fa; s_fixed_b <= w.fb;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    // Hold the sender until every outstanding result word is back.
    task automatic drain();
        s_valid <= 1'b0;
        while (forces_pending != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_spring(input logic [31:0] rest, input logic [31:0] k,
                              input logic [31:0] c, input logic en);
        drain();
        write_reg(CFG_REST_LENGTH, rest);
        write_reg(CFG_STIFFNESS, k);
        write_reg(CFG_DAMPING, c);
        write_reg(CFG_ENABLED, {31'd0, en});
        settings_run++;
    endtask

    // Coordinates: full range, extremes, near the origin, or a mid range.
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2:       return $signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_mass();
        case ($urandom_range(0, 3))
            0:       return 31'($urandom_range(1, 32'h7FFF_FFFF));
            1:       return 31'($urandom_range(1, 4));
            default: return 31'($urandom_range(1, 32'h0010_0000));
        endcase
    endfunction

    function automatic bodies_t rand_bodies();
        bodies_t w;
        w.pax = rand_coord(); w.pay = rand_coord();
        w.pbx = rand_coord(); w.pby = rand_coord();
        if ($urandom_range(0, 15) == 0) begin
            w.pbx = w.pax;
            w.pby = w.pay;
        end
        w.vax = rand_coord(); w.vay = rand_coord();
        w.vbx = rand_coord(); w.vby = rand_coord();
        w.ma = rand_mass(); w.mb = rand_mass();
        w.fa = ($urandom_range(0, 4) == 0);
        w.fb = ($urandom_range(0, 4) == 0);
        return w;
    endfunction

    function automatic logic [31:0] pick_reg31(input int sel);
        case (sel % 4)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h0;
            2:       return $urandom_range(0, 32'h0010_0000);
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] pick_damping(input int sel);
        case (sel % 6)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0;
            4:       return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        bodies_t w;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words: first one has zero distance and no held direction.
        set_spring(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 1'b1);
        w = '{0, 0, 0, 0, 32'sh0001_0000, 0, 0, 0, 31'h10000, 31'h10000, 0, 0};
        send_bodies(w);
        w.pbx = 32'sh0003_0000; w.pby = 32'sh0004_0000;
        send_bodies(w);
        w.pbx = 0; w.pby = 0;
        send_bodies(w);
        w.pax = 32'sh8000_0000; w.pay = 32'sh8000_0000;
        w.pbx = 32'sh7FFF_FFFF; w.pby = 32'sh7FFF_FFFF;
        send_bodies(w);
        w.pax = 32'sh7FFF_FFFF; w.pbx = 32'sh8000_0000; w.pby = 32'sh8000_0000;
        w.vax = 32'sh8000_0000; w.vay = 32'sh7FFF_FFFF;
        w.vbx = 32'sh7FFF_FFFF; w.vby = 32'sh8000_0000;
        send_bodies(w);
        w.fa = 1; send_bodies(w);
        w.fa = 0; w.fb = 1; send_bodies(w);
        w.fa = 1; send_bodies(w);
        w.fa = 0; w.fb = 0; w.ma = 31'h7FFF_FFFF; w.mb = 31'h7FFF_FFFF;
        send_bodies(w);
        set_spring(32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_bodies(w);
        w.ma = 1; w.mb = 1; w.pbx = 32'sh0000_0001; w.pby = 0; w.pax = 0; w.pay = 0;
        send_bodies(w);
        w.ma = 0; w.mb = 0;
        send_bodies(w);
        w.pbx = 0;
        send_bodies(w);
        set_spring(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_bodies(rand_bodies());
        send_bodies(rand_bodies());

        // Random words under a series of spring settings.
        for (int p = 0; p < 8; p++) begin
            set_spring(pick_reg31(p + 1), pick_reg31(p), pick_damping(p), p != 5);
            idling_on = (p != 2);
            for (int i = 0; i < 140; i++) begin
                if (i == 70 && p == 4) drain();
                send_bodies(rand_bodies());
            end
        end
        idling_on = 1'b1;

        drain();
        $display("Sent %0d body words and checked %0d force words", words_sent,
                 forces_checked);
        $display("across %0d spring settings, including disabled and critical damping.",
                 settings_run);
        if (fail_count == 0 && forces_pending == 0)
            $display("spring_damper_force_core: match");
        else
            $display("spring_damper_force_core: mismatch");
        $finish;
    end

endmodule

// ----- spring_damper_force_core.f -----
hw/rtl/sdf_pkg.sv
hw/rtl/sdf_mul.sv
hw/rtl/sdf_iter.sv
hw/rtl/spring_damper_force_core.sv
hw/rtl/sdf_checker.sv
tb/sdf_force_checker.sv
tb/tb_spring_damper_force_core.sv
